// ===== rtl/mbs_pkg.sv =====
// Shared types, constants and codes of the melody and bytebeat sample source.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mbs_pkg;

  // Storage sizes. Both depths are powers of two so that the sample address wraps by masking.
  localparam int SAMPLE_DEPTH = 4096;
  localparam int MELODY_DEPTH = 256;
  localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
  localparam int MELODY_AW    = $clog2(MELODY_DEPTH);

  // Field and state widths.
  localparam int ADDR_W   = 12;
  localparam int SMP_W    = 16;
  localparam int START_W  = 12;
  localparam int TLEN_W   = 13;
  localparam int DUR_W    = 16;
  localparam int MPOS_W   = 9;
  localparam int RPT_W    = 22;
  localparam int BEAT_W   = 16;
  localparam int PROD_W   = RPT_W + TLEN_W;
  localparam int ENTRY_W  = START_W + TLEN_W + DUR_W;
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 9;

  // Bytebeat constants.
  localparam logic [BEAT_W-1:0] BEAT1_LAST = 16'd8095;

  // Input kinds.
  localparam logic [1:0] KIND_TICK      = 2'd0;
  localparam logic [1:0] KIND_WR_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_WR_MELODY = 2'd2;
  localparam logic [1:0] KIND_RESTART   = 2'd3;

  // Operations handed from the front to the back.
  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_WR_SAMPLE = 2'd1;
  localparam logic [1:0] OP_WR_MELODY = 2'd2;
  localparam logic [1:0] OP_RESTART   = 2'd3;

  // Source modes.
  localparam logic [1:0] MODE_BEAT1 = 2'd1;
  localparam logic [1:0] MODE_BEAT2 = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_SOURCE_MODE   = 1'd0;
  localparam logic [CFG_IW-1:0] CFG_MELODY_LENGTH = 1'd1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  address;
    logic [SMP_W-1:0]   sample_value;
    logic [START_W-1:0] tone_start;
    logic [TLEN_W-1:0]  tone_length;
    logic [DUR_W-1:0]   duration;
  } in_item_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             song_done;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [ADDR_W-1:0]  address;
    logic [SMP_W-1:0]   sample_value;
    logic [START_W-1:0] tone_start;
    logic [TLEN_W-1:0]  tone_length;
    logic [DUR_W-1:0]   duration;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/melody_and_bytebeat_sample_source.sv =====
// Top level of the melody and bytebeat sample source.
// Uses mbs_pkg and connects mbs_front, mbs_queue and mbs_back.
`timescale 1ns / 1ps

// The input channel (in_valid/in_ready/in_data) carries one command per beat: a tick,
// a sample memory write, a melody entry write or a player restart. Only a tick makes a
// result beat on the output channel (out_valid/out_ready/out_data): one audio sample
// and the song-done flag. The cfg_ port writes source_mode or melody_length, one per
// write; write it only while no command is in flight.
// Accepted commands wait in a four-entry queue, so the input keeps taking beats while
// the back end works or the receiver stalls; in_ready drops only when that queue is full.
// The back end runs one command at a time. A write or restart is done from idle, a
// bytebeat tick goes on to output load, and a melody tick runs melody entry read,
// multiply, compare, sample read and output load, set by the chain of melody memory
// and sample memory reads; a tick at or past the song end skips to output load.
// A finished result sits in the output register until taken; the next tick finishes but
// waits for that register to free up while later commands stay queued.
// Reset (synchronous, rst_n low) clears the player counters, the registers, the queue and
// the output; sample and melody memory contents are kept and are undefined until written.
module melody_and_bytebeat_sample_source (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mbs_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mbs_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [mbs_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [mbs_pkg::CFG_DW-1:0]  cfg_data
);
  import mbs_pkg::*;

  q_stat_t q_stat;
  q_item_t push_data, pop_data;
  logic    push, pop;

  mbs_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  mbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  mbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (pop_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== rtl/mbs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; sized by its WIDTH and DEPTH parameters.
`timescale 1ns / 1ps

module mbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mbs_front.sv =====
// Input front: accepts beats, decodes the kind and drops out-of-range writes.
// Uses mbs_pkg; feeds mbs_queue.
`timescale 1ns / 1ps

module mbs_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  mbs_pkg::in_item_t in_data,
  input  mbs_pkg::q_stat_t  q_stat,
  output logic              push,
  output mbs_pkg::q_item_t  push_data
);
  import mbs_pkg::*;

  logic keep;

  assign in_ready = !q_stat.full;

  always_comb begin
    push_data.op           = OP_TICK;
    push_data.address      = in_data.address;
    push_data.sample_value = in_data.sample_value;
    push_data.tone_start   = in_data.tone_start;
    push_data.tone_length  = in_data.tone_length;
    push_data.duration     = in_data.duration;
    keep                   = 1'b1;
    unique case (in_data.kind)
      KIND_TICK: begin
        push_data.op = OP_TICK;
      end
      KIND_WR_SAMPLE: begin
        push_data.op = OP_WR_SAMPLE;
        keep         = (32'(in_data.address) < SAMPLE_DEPTH);
      end
      KIND_WR_MELODY: begin
        push_data.op = OP_WR_MELODY;
        keep         = (32'(in_data.address) < MELODY_DEPTH);
      end
      KIND_RESTART: begin
        push_data.op = OP_RESTART;
      end
    endcase
  end

  // An ignored write is still taken off the channel, it just never reaches the back.
  assign push = in_valid && in_ready && keep;

endmodule

// ===== rtl/mbs_queue.sv =====
// Four-entry register queue between the front and the back.
// Uses mbs_pkg for the entry and status types.
`timescale 1ns / 1ps

module mbs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mbs_pkg::q_item_t push_data,
  input  logic             pop,
  output mbs_pkg::q_item_t pop_data,
  output mbs_pkg::q_stat_t q_stat
);
  import mbs_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  q_item_t          entries_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (count_r == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mbs_back.sv =====
// Back end: executes queued operations, owns the player state, both memories and the
// output register. Uses mbs_pkg and mbs_ram.
`timescale 1ns / 1ps

module mbs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbs_pkg::q_item_t              pop_data,
  input  mbs_pkg::q_stat_t              q_stat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mbs_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [mbs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [mbs_pkg::CFG_DW-1:0]    cfg_data
);
  import mbs_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MEL_RD  = 3'd1;
  localparam logic [2:0] ST_MEL_MUL = 3'd2;
  localparam logic [2:0] ST_MEL_CMP = 3'd3;
  localparam logic [2:0] ST_SMP_RD  = 3'd4;
  localparam logic [2:0] ST_OUT     = 3'd5;

  localparam logic [MPOS_W-1:0] MEL_DEPTH_L = MPOS_W'(MELODY_DEPTH);

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [MPOS_W-1:0]   mlen_r, mlen_nxt;
  logic [TLEN_W-1:0]   tp_r, tp_nxt;
  logic [RPT_W-1:0]    rc_r, rc_nxt;
  logic [MPOS_W-1:0]   mp_r, mp_nxt;
  logic [BEAT_W-1:0]   bt_r, bt_nxt;

  logic [START_W-1:0]  ent_start_r, ent_start_nxt;
  logic [TLEN_W-1:0]   ent_len_r, ent_len_nxt;
  logic [DUR_W-1:0]    ent_dur_r, ent_dur_nxt;
  logic [START_W-1:0]  nxt_start_r, nxt_start_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [RPT_W-1:0]    thr_r, thr_nxt;
  logic [SMP_W-1:0]    pend_sample_r, pend_sample_nxt;
  logic                pend_done_r, pend_done_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic                  mel_we, smp_we;
  logic [MELODY_AW-1:0]  mel_raddr;
  logic [SAMPLE_AW-1:0]  smp_raddr;
  logic [ENTRY_W-1:0]    mel_wdata, mel_rdata;
  logic [SMP_W-1:0]      smp_rdata;

  logic [MPOS_W-1:0]   len_eff, mp_inc, mp_new;
  logic [TLEN_W-1:0]   tp_inc, rd_len;
  logic [BEAT_W-1:0]   t1, t1_raw, t2, t1_x5, t1_x3;
  logic [8:0]          b2_dbl, b2_sum, b2_val;
  logic [START_W-1:0]  sel_start;
  logic [TLEN_W:0]     smp_sum;
  logic                adv;

  assign mel_wdata = {pop_data.tone_start, pop_data.tone_length, pop_data.duration};
  assign rd_len    = mel_rdata[DUR_W +: TLEN_W];

  mbs_ram #(.WIDTH(ENTRY_W), .DEPTH(MELODY_DEPTH)) u_mel_ram (
    .clk   (clk),
    .we    (mel_we),
    .waddr (MELODY_AW'(pop_data.address)),
    .wdata (mel_wdata),
    .raddr (mel_raddr),
    .rdata (mel_rdata)
  );

  mbs_ram #(.WIDTH(SMP_W), .DEPTH(SAMPLE_DEPTH)) u_smp_ram (
    .clk   (clk),
    .we    (smp_we),
    .waddr (SAMPLE_AW'(pop_data.address)),
    .wdata (pop_data.sample_value),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  // Bytebeat datapaths; the first formula's time never exceeds 8095, so its
  // modulo-4095 term is at most 7 and passes unchanged.
  always_comb begin
    t1_raw = bt_r + 1'b1;
    t1     = (t1_raw > BEAT1_LAST) ? '0 : t1_raw;
    t1_x5  = t1 + {t1[BEAT_W-3:0], 2'b00};
    t1_x3  = t1 + {t1[BEAT_W-2:0], 1'b0};
    t2     = bt_r + 1'b1;
    // Only the low nine bits survive the final mask, and carries only run upward.
    b2_dbl = {t2[7:0], 1'b0};
    b2_sum = b2_dbl + t2[15:7];
    b2_val = (b2_dbl ^ (b2_sum & 9'(t2 >> 12))) | t2[11:3] | t2[15:7];
  end

  always_comb begin
    len_eff   = (mlen_r < MEL_DEPTH_L) ? mlen_r : MEL_DEPTH_L;
    mp_inc    = mp_r + 1'b1;
    tp_inc    = tp_r + 1'b1;
    adv       = (prod_r > PROD_W'(thr_r));
    mp_new    = adv ? mp_inc : mp_r;
    sel_start = adv ? nxt_start_r : ent_start_r;
    smp_sum   = (TLEN_W+1)'(sel_start) + (TLEN_W+1)'(tp_r);
  end

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    mlen_nxt        = mlen_r;
    tp_nxt          = tp_r;
    rc_nxt          = rc_r;
    mp_nxt          = mp_r;
    bt_nxt          = bt_r;
    ent_start_nxt   = ent_start_r;
    ent_len_nxt     = ent_len_r;
    ent_dur_nxt     = ent_dur_r;
    nxt_start_nxt   = nxt_start_r;
    prod_nxt        = prod_r;
    thr_nxt         = thr_r;
    pend_sample_nxt = pend_sample_r;
    pend_done_nxt   = pend_done_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    pop             = 1'b0;
    mel_we          = 1'b0;
    smp_we          = 1'b0;
    mel_raddr       = mp_r[MELODY_AW-1:0];
    smp_raddr       = SAMPLE_AW'(smp_sum);

    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          unique case (pop_data.op)
            OP_WR_SAMPLE: smp_we = 1'b1;
            OP_WR_MELODY: mel_we = 1'b1;
            OP_RESTART: begin
              tp_nxt   = '0;
              rc_nxt   = '0;
              mp_nxt   = '0;
              bt_nxt   = '0;
              mode_nxt = '0;
            end
            OP_TICK: begin
              pend_done_nxt = 1'b0;
              if (mode_r == MODE_BEAT1) begin
                bt_nxt          = t1;
                pend_sample_nxt = (t1_x5 & (t1 >> 7)) | (t1_x3 & (t1 >> 10));
                state_nxt       = ST_OUT;
              end else if (mode_r == MODE_BEAT2) begin
                bt_nxt          = t2;
                pend_sample_nxt = SMP_W'(b2_val);
                state_nxt       = ST_OUT;
              end else if (mp_r >= len_eff) begin
                // End of the melody: clear the player and report it.
                tp_nxt          = '0;
                rc_nxt          = '0;
                mp_nxt          = '0;
                bt_nxt          = '0;
                mode_nxt        = '0;
                pend_sample_nxt = '0;
                pend_done_nxt   = 1'b1;
                state_nxt       = ST_OUT;
              end else begin
                state_nxt = ST_MEL_RD;
              end
            end
          endcase
        end
      end
      ST_MEL_RD: begin
        ent_start_nxt = mel_rdata[ENTRY_W-1 -: START_W];
        ent_len_nxt   = rd_len;
        ent_dur_nxt   = mel_rdata[DUR_W-1:0];
        if (tp_inc == rd_len) begin
          tp_nxt = '0;
          if (rc_r != '1) begin
            rc_nxt = rc_r + 1'b1;
          end
        end else begin
          tp_nxt = tp_inc;
        end
        // Fetch the following entry now in case this tick moves on.
        mel_raddr = mp_inc[MELODY_AW-1:0];
        state_nxt = ST_MEL_MUL;
      end
      ST_MEL_MUL: begin
        prod_nxt      = PROD_W'(rc_r) * PROD_W'(ent_len_r);
        // prod / 33 > dur is the same as prod > 33 * dur + 32.
        thr_nxt       = RPT_W'({ent_dur_r, 5'b00000}) + RPT_W'(ent_dur_r) + RPT_W'(32);
        nxt_start_nxt = mel_rdata[ENTRY_W-1 -: START_W];
        state_nxt     = ST_MEL_CMP;
      end
      ST_MEL_CMP: begin
        if (adv) begin
          rc_nxt = '0;
          mp_nxt = mp_new;
        end
        if (mp_new >= len_eff) begin
          pend_sample_nxt = '0;
          state_nxt       = ST_OUT;
        end else begin
          state_nxt = ST_SMP_RD;
        end
      end
      ST_SMP_RD: begin
        pend_sample_nxt = smp_rdata;
        state_nxt       = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.sample    = pend_sample_r;
          out_data_nxt.song_done = pend_done_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCE_MODE:   mode_nxt = cfg_data[1:0];
        CFG_MELODY_LENGTH: mlen_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= '0;
      mlen_r      <= '0;
      tp_r        <= '0;
      rc_r        <= '0;
      mp_r        <= '0;
      bt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      mlen_r      <= mlen_nxt;
      tp_r        <= tp_nxt;
      rc_r        <= rc_nxt;
      mp_r        <= mp_nxt;
      bt_r        <= bt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_start_r   <= ent_start_nxt;
    ent_len_r     <= ent_len_nxt;
    ent_dur_r     <= ent_dur_nxt;
    nxt_start_r   <= nxt_start_nxt;
    prod_r        <= prod_nxt;
    thr_r         <= thr_nxt;
    pend_sample_r <= pend_sample_nxt;
    pend_done_r   <= pend_done_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for melody_and_bytebeat_sample_source: preloads the sample window
// and the melody entries that get played, then runs directed and random command streams
// under random idling on both channels. Depends on rtl/mbs_pkg.sv and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import mbs_pkg::*;

  localparam logic [1:0] MODE_MELODY = 2'd0;
  localparam int CYCLE_LIMIT  = 300_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 40;
  localparam int RANDOM_ITEMS = 1000;
  localparam int WIN_BASE     = SAMPLE_DEPTH - 64;
  localparam int WIN_WORDS    = 128;
  localparam int SONG_ENTRIES = 16;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IW-1:0]    cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_data  = '0;

  melody_and_bytebeat_sample_source u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Player model state, including its own copy of both registers.
  logic [1:0]          play_mode = MODE_MELODY;
  logic [MPOS_W-1:0]   song_len  = '0;
  logic [TLEN_W-1:0]   tone_pos  = '0;
  logic [RPT_W-1:0]    repeats   = '0;
  logic [MPOS_W-1:0]   song_pos  = '0;
  logic [BEAT_W-1:0]   beat_time = '0;
  logic [SMP_W-1:0]    pcm_mem   [SAMPLE_DEPTH];
  logic [START_W-1:0]  note_start[MELODY_DEPTH];
  logic [TLEN_W-1:0]   note_len  [MELODY_DEPTH];
  logic [DUR_W-1:0]    note_dur  [MELODY_DEPTH];

  in_item_t  cmd_backlog[$];
  out_item_t samples_due[$];

  logic in_accepted = 1'b0;
  int   errors      = 0;
  int   cmds_taken  = 0;
  int   ticks_taken = 0;
  int   n_checked   = 0;
  int   n_song_ends = 0;
  int   n_cfg_wr    = 0;
  int   cycle_count = 0;

  function automatic void clear_player();
    tone_pos  = '0;
    repeats   = '0;
    song_pos  = '0;
    beat_time = '0;
    play_mode = MODE_MELODY;
  endfunction

  function automatic out_item_t melody_step();
    out_item_t         r;
    int                eff;
    logic [TLEN_W-1:0] tl;
    logic [13:0]       sum;
    longint unsigned   prod;
    r = '0;
    eff = (song_len < MELODY_DEPTH) ? int'(song_len) : MELODY_DEPTH;
    if (int'(song_pos) >= eff) begin
      clear_player();
      r.song_done = 1'b1;
      return r;
    end
    tl = note_len[song_pos];
    tone_pos = tone_pos + 1'b1;
    if (tone_pos == tl) begin
      tone_pos = '0;
      if (repeats != '1) repeats = repeats + 1'b1;
    end
    prod = 64'(repeats) * 64'(tl);
    if (prod / 33 > 64'(note_dur[song_pos])) begin
      repeats  = '0;
      song_pos = song_pos + 1'b1;
    end
    // Having just stepped past the last entry reads as silence; the end is flagged next tick.
    if (int'(song_pos) >= eff) return r;
    sum = note_start[song_pos] + tone_pos;
    r.sample = pcm_mem[sum[SAMPLE_AW-1:0]];
    return r;
  endfunction

  function automatic out_item_t beat_step();
    out_item_t   r;
    int unsigned t;
    r = '0;
    beat_time = beat_time + 1'b1;
    if (play_mode == MODE_BEAT1) begin
      if (beat_time > BEAT1_LAST) beat_time = '0;
      t = beat_time;
      r.sample = 16'(((t * 5) & (t >> 7)) | (((t * 3) & (t >> 10)) % 4095));
    end else begin
      t = beat_time;
      // The upper time bits that would select another shift are always zero here.
      r.sample = 16'((((t << 1) ^ (((t << 1) + (t >> 7)) & (t >> 12))) | (t >> 3) | (t >> 7))
                     & 32'h1FF);
    end
    return r;
  endfunction

  function automatic void apply_cmd(in_item_t c);
    case (c.kind)
      KIND_WR_SAMPLE: begin
        pcm_mem[c.address] = c.sample_value;
      end
      KIND_WR_MELODY: begin
        if (c.address < MELODY_DEPTH) begin
          note_start[c.address] = c.tone_start;
          note_len[c.address]   = c.tone_length;
          note_dur[c.address]   = c.duration;
        end
      end
      KIND_RESTART: begin
        clear_player();
      end
      default: begin
        if (play_mode == MODE_BEAT1 || play_mode == MODE_BEAT2) samples_due.push_back(beat_step());
        else samples_due.push_back(melody_step());
      end
    endcase
  endfunction

  function automatic in_item_t random_cmd(logic [1:0] kind);
    in_item_t c;
    c.kind         = kind;
    c.address      = ADDR_W'($urandom_range(4095));
    c.sample_value = SMP_W'($urandom_range(65535));
    c.tone_start   = START_W'($urandom_range(4095));
    c.tone_length  = TLEN_W'($urandom_range(4096, 1));
    c.duration     = DUR_W'($urandom_range(65535));
    return c;
  endfunction

  function automatic in_item_t melody_entry(int idx, int start, int len, int dur);
    in_item_t c;
    c = random_cmd(KIND_WR_MELODY);
    c.address     = ADDR_W'(idx);
    c.tone_start  = START_W'(start);
    c.tone_length = TLEN_W'(len);
    c.duration    = DUR_W'(dur);
    return c;
  endfunction

  // Tones start near the top of sample memory, so every tone that is played stays inside
  // the preloaded window, wrapping through address zero.
  function automatic int safe_start();
    return WIN_BASE + int'($urandom_range(63));
  endfunction

  // Tone lengths never shrink along the song, so the tone position always stays below the
  // length of the entry that the player moves on to.
  function automatic int note_length(int idx);
    return 8 + 2 * idx;
  endfunction

  task automatic queue_ticks(int n);
    repeat (n) cmd_backlog.push_back(random_cmd(KIND_TICK));
  endtask

  // Waits until every command is taken and every sample has come back, then lets
  // trailing writes drain out of the block.
  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || in_valid || samples_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SOURCE_MODE) play_mode = val[1:0];
    else song_len = val[MPOS_W-1:0];
    n_cfg_wr++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin : sender
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (in_valid && !in_accepted) begin
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (cmd_backlog.size() > 0) begin
      in_data  <= cmd_backlog.pop_front();
      in_valid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(24, 1);
        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: short stalls, long open stretches, and two long hold-offs that fill the block.
  always @(negedge clk) begin : receiver
    int stall_left;
    int open_left;
    int hold_left;
    int holds_done;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
      open_left  = 0;
      hold_left  = 0;
      holds_done = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_done < 2 && n_checked >= ((holds_done == 0) ? 500 : 800)) begin
      holds_done++;
      hold_left = 400;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (open_left > 0) begin
      open_left--;
      out_ready <= 1'b1;
    end else begin
      open_left  = ($urandom_range(3) == 0) ? $urandom_range(80, 30) : $urandom_range(5, 1);
      stall_left = $urandom_range(4);
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    in_accepted <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      cmds_taken++;
      if (in_data.kind == KIND_TICK) ticks_taken++;
      apply_cmd(in_data);
    end
    if (rst_n && out_valid && out_ready) begin
      if (samples_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected sample beat, expected none, got sample %h done %b",
                   $time, out_data.sample, out_data.song_done);
      end else begin
        want = samples_due.pop_front();
        n_checked++;
        if (out_data.song_done) n_song_ends++;
        if (out_data.sample !== want.sample) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: sample mismatch, expected %h, got %h",
                     $time, want.sample, out_data.sample);
        end
        if (out_data.song_done !== want.song_done) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: song_done mismatch, expected %b, got %b",
                     $time, want.song_done, out_data.song_done);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d samples still due",
               $time, cycle_count, samples_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t c;
    int       random_items;
    int       n;
    int       r;
    int       j;
    logic [1:0] mode;
    int       len;
    random_items = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_SOURCE_MODE, CFG_DW'(MODE_MELODY));
    write_reg(CFG_MELODY_LENGTH, '0);

    // Load the sample window around address zero and the melody entries a song can reach,
    // so no read ever hits unwritten memory.
    for (int a = 0; a < WIN_WORDS; a++) begin
      c = random_cmd(KIND_WR_SAMPLE);
      c.address = ADDR_W'(WIN_BASE + a);
      if (c.address == '0) c.sample_value = '0;
      if (c.address == '1) c.sample_value = '1;
      cmd_backlog.push_back(c);
    end
    for (int i = 0; i < SONG_ENTRIES; i++)
      cmd_backlog.push_back(melody_entry(i, safe_start(), note_length(i), $urandom_range(1)));

    // Directed: empty melody ends at once; a write past the melody store is dropped.
    queue_ticks(1);
    cmd_backlog.push_back(melody_entry(4095, 4095, 4096, 65535));
    // One-entry song near the top of sample memory: addresses wrap, the step past the
    // end reads silence, the end is flagged on the next tick, and the song replays.
    cmd_backlog.push_back(melody_entry(0, 4090, 33, 0));
    wait_idle();
    write_reg(CFG_MELODY_LENGTH, 9'd1);
    queue_ticks(35);
    // A zero tone length never finishes until a restart.
    cmd_backlog.push_back(melody_entry(0, 0, 0, 0));
    queue_ticks(3);
    cmd_backlog.push_back(random_cmd(KIND_RESTART));
    cmd_backlog.push_back(melody_entry(0, 4095, 4096, 65535));
    queue_ticks(2);
    cmd_backlog.push_back(random_cmd(KIND_RESTART));
    wait_idle();
    write_reg(CFG_SOURCE_MODE, CFG_DW'(MODE_BEAT1));
    queue_ticks(3);
    // Restart drops back to melody mode.
    cmd_backlog.push_back(random_cmd(KIND_RESTART));
    queue_ticks(1);
    wait_idle();
    write_reg(CFG_SOURCE_MODE, CFG_DW'(MODE_BEAT2));
    write_reg(CFG_MELODY_LENGTH, 9'd256);
    queue_ticks(3);

    // Put the first entry back in song shape and play a little of the full-length melody.
    cmd_backlog.push_back(melody_entry(0, safe_start(), note_length(0), 0));
    cmd_backlog.push_back(random_cmd(KIND_RESTART));
    queue_ticks(20);

    // Bytebeat runs long enough to reach the time terms shifted right by seven in both formulas.
    wait_idle();
    write_reg(CFG_SOURCE_MODE, CFG_DW'(MODE_BEAT1));
    queue_ticks(150);
    wait_idle();
    write_reg(CFG_SOURCE_MODE, CFG_DW'(MODE_BEAT2));
    queue_ticks(150);

    // Random phases: mostly short songs played through, with writes, restarts and noise.
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      r = $urandom_range(3);
      mode = (r == 2) ? MODE_BEAT1 : (r == 3) ? MODE_BEAT2 : MODE_MELODY;
      r = $urandom_range(9);
      len = (r == 0) ? 0 : (r == 1) ? SONG_ENTRIES
          : (r == 2) ? $urandom_range(SONG_ENTRIES, 1) : $urandom_range(4, 1);
      write_reg(CFG_SOURCE_MODE, CFG_DW'(mode));
      write_reg(CFG_MELODY_LENGTH, CFG_DW'(len));
      if (mode == MODE_MELODY && len > 0 && len <= 4 && $urandom_range(1) == 1) begin
        for (int i = 0; i < len; i++) begin
          cmd_backlog.push_back(melody_entry(i, safe_start(), note_length(i),
                                             $urandom_range(1)));
          random_items++;
        end
      end
      n = $urandom_range(250, 60);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(99);
        if (r < 75) begin
          cmd_backlog.push_back(random_cmd(KIND_TICK));
        end else if (r < 85) begin
          cmd_backlog.push_back(random_cmd(KIND_WR_SAMPLE));
        end else if (r < 92) begin
          c = random_cmd(KIND_WR_MELODY);
          c.address = ADDR_W'($urandom_range(MELODY_DEPTH - 1, SONG_ENTRIES));
          cmd_backlog.push_back(c);
        end else if (r < 95) begin
          c = random_cmd(KIND_WR_MELODY);
          c.address = ADDR_W'($urandom_range(4095, MELODY_DEPTH));
          cmd_backlog.push_back(c);
        end else if (r < 97) begin
          j = $urandom_range(3);
          cmd_backlog.push_back(melody_entry(j, safe_start(), note_length(j),
                                             $urandom_range(1)));
        end else begin
          cmd_backlog.push_back(random_cmd(KIND_RESTART));
        end
        random_items++;
      end
    end

    wait_idle();
    errors += samples_due.size();
    $display("Run covered %0d commands (%0d ticks), %0d register writes, %0d cycles.",
             cmds_taken, ticks_taken, n_cfg_wr, cycle_count);
    $display("Checked %0d samples, %0d of them flagged a song end.", n_checked, n_song_ends);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
